/* rtl/iacl_pkg.sv */
// ----------------------------------------------------------------------------
// iacl_pkg
// Types, codes and defaults shared by the IPv4 connect ACL check block.
// ----------------------------------------------------------------------------
`default_nettype none

package iacl_pkg;

  localparam int RuleDepthDef = 16;

  localparam logic [15:0] FamIpv4 = 16'd2;
  localparam logic [15:0] FamIpv6 = 16'd10;

  localparam logic [31:0] AddrAllOnes = 32'hFFFF_FFFF;

  localparam logic [15:0] TlsPortADef = 16'd443;
  localparam logic [15:0] TlsPortBDef = 16'd8443;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POLICY_MANAGED = 3'd0,
    CFG_RULE_COUNT     = 3'd1,
    CFG_DENY_CLEARTEXT = 3'd2,
    CFG_ENFORCE_MODE   = 3'd3,
    CFG_TLS_PORT_A     = 3'd4,
    CFG_TLS_PORT_B     = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_CONNECT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_PERMIT  = 2'd0,
    STATUS_BLOCKED = 2'd1,
    STATUS_PRIOR   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    EVT_ALLOW = 2'd0,
    EVT_AUDIT = 2'd1,
    EVT_DENY  = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [3:0]  rule_slot;
    logic [31:0] rule_address;
    logic [5:0]  rule_prefix;
    logic [15:0] rule_port;
    logic [15:0] addr_family;
    logic [31:0] dest_address;
    logic [15:0] dest_port;
    logic        prior_refused;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        event_valid;
    logic [1:0]  event_verdict;
    logic [15:0] event_family;
    logic [15:0] event_port;
    logic [31:0] event_address;
  } out_item_t;

  // One table entry as stored in the rule memory
  typedef struct packed {
    logic [31:0] address;
    logic [5:0]  prefix;
    logic [15:0] port;
  } rule_t;

endpackage

`default_nettype wire

/* rtl/iacl_rule_match.sv */
// ----------------------------------------------------------------------------
// iacl_rule_match
// Compares one stored rule against a connect destination under the prefix
// mask, with port 0 in the rule matching any port.
// ----------------------------------------------------------------------------
`default_nettype none

module iacl_rule_match (
  input  iacl_pkg::rule_t rule_i,
  input  logic [31:0]     dest_address_i,
  input  logic [15:0]     dest_port_i,
  output logic            hit_o
);
  import iacl_pkg::*;

  logic [31:0] mask;
  logic        addr_eq;
  logic        port_ok;

  // prefix of 32 and above is the full mask; 0 gives an empty mask that matches any address
  assign mask    = rule_i.prefix[5] ? AddrAllOnes : ~(AddrAllOnes >> rule_i.prefix[4:0]);
  assign addr_eq = (dest_address_i & mask) == (rule_i.address & mask);
  assign port_ok = (rule_i.port == 16'd0) || (rule_i.port == dest_port_i);
  assign hit_o   = addr_eq && port_ok;

endmodule

`default_nettype wire

/* rtl/ipv4_connect_acl_check.sv */
// ----------------------------------------------------------------------------
// ipv4_connect_acl_check
// Outbound IPv4 connect filter against a prefix/port rule table.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries load items, which write one
// rule into the table if rule_slot is below RULE_DEPTH, and connect items,
// which each give one result on the output channel (out_valid_o /
// out_stall_i). Load items give no result. A connect item that scans the
// table reads n rules, where n is the number of rules scanned (rule_count,
// capped at RULE_DEPTH): the rule memory gives one entry per cycle in the
// scan state, then a drain state follows, and the decision state loads the result
// register. Connects that need no scan (earlier refusal, unmanaged policy,
// non-IPv4, or no rules to scan) go straight to the decision state.
// Only one connect is in work at a time; the next item is taken as soon as
// the result sits in the output register, even while that result is stalled.
// A stalled output holds its item; a finished connect waits in the decision
// state until the output register frees up.
// Reset clears the configuration registers to their defaults and the control
// state; the rule table is not cleared and must be written before it is read.
// Configuration writes (cfg_valid_i / cfg_ready_o) are taken while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_connect_acl_check #(
  parameter int RULE_DEPTH = iacl_pkg::RuleDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  iacl_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output iacl_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [iacl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [iacl_pkg::CfgDataW-1:0]   cfg_data_i
);
  import iacl_pkg::*;

  localparam int IdxW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
  localparam int CntW = ($clog2(RULE_DEPTH + 1) > 5) ? $clog2(RULE_DEPTH + 1) : 5;
  localparam logic [CntW-1:0] DepthC = CntW'(RULE_DEPTH);

  // configuration
  logic        policy_managed_q;
  logic [4:0]  rule_count_q;
  logic        deny_cleartext_q;
  logic        enforce_mode_q;
  logic [15:0] tls_port_a_q;
  logic [15:0] tls_port_b_q;

  // control
  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q;
  logic            cmp_vld_q;
  logic            hit_q;
  logic            out_valid_q;

  // payload
  logic [15:0] conn_family_q;
  logic [31:0] conn_address_q;
  logic [15:0] conn_port_q;
  logic        conn_refused_q;
  out_item_t   out_q;
  rule_t       rule_mem_q [RULE_DEPTH];
  rule_t       rd_rule_q;

  logic            in_accept;
  logic            is_connect;
  logic            need_scan;
  logic            slot_ok;
  logic            mem_we;
  logic            rd_en;
  logic            out_free;
  logic            out_load;
  logic            last_issue;
  logic            rule_hit;
  logic [CntW-1:0] rule_count_ext;
  logic [CntW-1:0] scan_len;
  rule_t           wr_rule;
  out_item_t       res_d;

  assign rule_count_ext = CntW'(rule_count_q);
  assign scan_len       = (rule_count_ext > DepthC) ? DepthC : rule_count_ext;
  assign last_issue     = (CntW'(idx_q) + CntW'(1)) == scan_len;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_connect = in_item_i.kind == KIND_CONNECT;
  assign slot_ok    = CntW'(in_item_i.rule_slot) < DepthC;
  assign need_scan  = !in_item_i.prior_refused && policy_managed_q &&
                      (in_item_i.addr_family == FamIpv4) && (scan_len != '0);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign wr_rule.address = in_item_i.rule_address;
  assign wr_rule.prefix  = in_item_i.rule_prefix;
  assign wr_rule.port    = in_item_i.rule_port;

  // ---------------------------------------------------------------------------
  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && is_connect) begin
          state_d = need_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cfg_ready_o = 1'b1;
        mem_we      = in_valid_i && !is_connect && slot_ok;
      end
      ST_SCAN: rd_en = 1'b1;
      ST_LAST: ;
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // rule memory: written by load items while idle, read once per scan cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rule_mem_q[IdxW'(in_item_i.rule_slot)] <= wr_rule;
    end
    if (rd_en) begin
      rd_rule_q <= rule_mem_q[idx_q];
    end
  end

  iacl_rule_match u_match (
    .rule_i         (rd_rule_q),
    .dest_address_i (conn_address_q),
    .dest_port_i    (conn_port_q),
    .hit_o          (rule_hit)
  );

  // scan control; each compare runs in the cycle after its read address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      cmp_vld_q <= rd_en;
      if (in_accept && is_connect) begin
        idx_q <= '0;
        hit_q <= 1'b0;
      end else begin
        if (rd_en && !last_issue) begin
          idx_q <= idx_q + IdxW'(1);
        end
        if (cmp_vld_q && rule_hit) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && is_connect) begin
      conn_family_q  <= in_item_i.addr_family;
      conn_address_q <= in_item_i.dest_address;
      conn_port_q    <= in_item_i.dest_port;
      conn_refused_q <= in_item_i.prior_refused;
    end
  end

  // ---------------------------------------------------------------------------
  // decision
  always_comb begin
    logic ok;
    ok    = hit_q && !(deny_cleartext_q && (conn_port_q != tls_port_a_q) &&
                       (conn_port_q != tls_port_b_q));
    res_d = '0;
    priority if (conn_refused_q) begin
      res_d.status = STATUS_PRIOR;
    end else if (!policy_managed_q) begin
      res_d.status = STATUS_PERMIT;
    end else if (conn_family_q == FamIpv6) begin
      res_d.event_valid   = 1'b1;
      res_d.event_verdict = EVT_AUDIT;
      res_d.event_family  = conn_family_q;
      res_d.event_port    = conn_port_q;
    end else if (conn_family_q == FamIpv4) begin
      res_d.event_valid   = 1'b1;
      res_d.event_family  = conn_family_q;
      res_d.event_port    = conn_port_q;
      res_d.event_address = conn_address_q;
      if (ok) begin
        res_d.event_verdict = EVT_ALLOW;
      end else if (enforce_mode_q) begin
        res_d.event_verdict = EVT_DENY;
        res_d.status        = STATUS_BLOCKED;
      end else begin
        res_d.event_verdict = EVT_AUDIT;
      end
    end else begin
      res_d.status = STATUS_PERMIT;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------------------
  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_managed_q <= 1'b0;
      rule_count_q     <= '0;
      deny_cleartext_q <= 1'b0;
      enforce_mode_q   <= 1'b0;
      tls_port_a_q     <= TlsPortADef;
      tls_port_b_q     <= TlsPortBDef;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_POLICY_MANAGED: policy_managed_q <= cfg_data_i[0];
        CFG_RULE_COUNT:     rule_count_q     <= cfg_data_i[4:0];
        CFG_DENY_CLEARTEXT: deny_cleartext_q <= cfg_data_i[0];
        CFG_ENFORCE_MODE:   enforce_mode_q   <= cfg_data_i[0];
        CFG_TLS_PORT_A:     tls_port_a_q     <= cfg_data_i;
        CFG_TLS_PORT_B:     tls_port_b_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/iacl_checker.sv */
// ----------------------------------------------------------------------------
// iacl_checker
// Port-level checks on the IPv4 connect ACL block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module iacl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input iacl_pkg::in_item_t            in_item_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input iacl_pkg::out_item_t           out_item_o
);
  import iacl_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // blocked here only on a deny event
  a_blocked_deny: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == STATUS_BLOCKED) |->
      out_item_o.event_valid && (out_item_o.event_verdict == EVT_DENY))
    else $error("blocked status without deny event");

  // no event fields without an event, and no event on a passed-through refusal
  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.event_valid |->
      (out_item_o.event_verdict == '0) && (out_item_o.event_family == '0) &&
      (out_item_o.event_port == '0) && (out_item_o.event_address == '0))
    else $error("event fields set without event");

  a_prior_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == STATUS_PRIOR) |-> !out_item_o.event_valid)
    else $error("event on passed-through refusal");

  // a connect item occupies the block for at least the next cycle
  a_connect_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_item_i.kind == KIND_CONNECT) |=> in_stall_o)
    else $error("input taken right after a connect item");

endmodule

bind ipv4_connect_acl_check iacl_checker u_iacl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
